@@ src/rig_pkg.sv @@
// Shared types and constants for the range innovation gate.
`default_nettype none
package rig_pkg;

	// Fixed field widths
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned NOISE_W = 16;
	localparam int unsigned UNOISE_W = 21;
	localparam int unsigned COUNT_W = 16;

	// APB register map
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam logic [2:0] REG_GATE_MM        = 3'd0;
	localparam logic [2:0] REG_RATE_MM_PER_S  = 3'd1;
	localparam logic [2:0] REG_HOLD_FARTHER   = 3'd2;
	localparam logic [2:0] REG_HOLD_CLOSER    = 3'd3;
	localparam logic [2:0] REG_STABLE_MM      = 3'd4;
	localparam logic [2:0] REG_PIN_SCALE      = 3'd5;
	localparam logic [2:0] REG_FLOW_SKIP_EN   = 3'd6;

	// Register reset values
	localparam logic [9:0]  RST_GATE_MM       = 10'd100;
	localparam logic [13:0] RST_RATE_MM_PER_S = 14'd300;
	localparam logic [15:0] RST_HOLD_FARTHER  = 16'd40;
	localparam logic [15:0] RST_HOLD_CLOSER   = 16'd200;
	localparam logic [9:0]  RST_STABLE_MM     = 10'd50;
	localparam logic [7:0]  RST_PIN_SCALE     = 8'd16;
	localparam logic        RST_FLOW_SKIP_EN  = 1'b1;

	// Arithmetic constants
	localparam logic [DIST_W-1:0]   MIN_RANGE_MM = 16'd20;
	localparam logic [9:0]          UM_PER_MM    = 10'd1000;
	localparam logic [UNOISE_W-1:0] NOISE_MAX    = 21'h1FFFFF;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_GROUND = 3'd1,
		ACT_ACCEPT = 3'd2,
		ACT_PIN    = 3'd3,
		ACT_COAST  = 3'd4
	} action_t;

	typedef struct packed {
		logic [DIST_W-1:0]  distance_mm;
		logic [TIME_W-1:0]  time_ms;
		logic [NOISE_W-1:0] noise_mm;
		logic               flying;
		logic               tilt_ok;
	} meas_t;

	typedef struct packed {
		action_t             action;
		logic [DIST_W-1:0]   reference_mm;
		logic [UNOISE_W-1:0] update_noise;
		logic [COUNT_W-1:0]  reject_run;
		logic                flow_skip;
	} res_t;

	typedef struct packed {
		logic [9:0]  gate_mm;
		logic [13:0] rate_mm_per_s;
		logic [15:0] hold_farther;
		logic [15:0] hold_closer;
		logic [9:0]  stable_mm;
		logic [7:0]  pin_scale_eighths;
		logic        flow_skip_enable;
	} cfg_t;

	typedef struct packed {
		logic               ref_valid;
		logic [DIST_W-1:0]  ref_distance;
		logic [TIME_W-1:0]  ref_time;
		logic [DIST_W-1:0]  prev_distance;
		logic [COUNT_W-1:0] reject_count;
		logic               gated_flag;
	} gate_state_t;

endpackage
`default_nettype wire

@@ src/rig_cfg.sv @@
// APB configuration register file for the range innovation gate.
`default_nettype none
module rig_cfg import rig_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes, truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_mm           <= RST_GATE_MM;
			cfg_q.rate_mm_per_s     <= RST_RATE_MM_PER_S;
			cfg_q.hold_farther      <= RST_HOLD_FARTHER;
			cfg_q.hold_closer       <= RST_HOLD_CLOSER;
			cfg_q.stable_mm         <= RST_STABLE_MM;
			cfg_q.pin_scale_eighths <= RST_PIN_SCALE;
			cfg_q.flow_skip_enable  <= RST_FLOW_SKIP_EN;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GATE_MM:       cfg_q.gate_mm           <= pwdata[9:0];
				REG_RATE_MM_PER_S: cfg_q.rate_mm_per_s     <= pwdata[13:0];
				REG_HOLD_FARTHER:  cfg_q.hold_farther      <= pwdata[15:0];
				REG_HOLD_CLOSER:   cfg_q.hold_closer       <= pwdata[15:0];
				REG_STABLE_MM:     cfg_q.stable_mm         <= pwdata[9:0];
				REG_PIN_SCALE:     cfg_q.pin_scale_eighths <= pwdata[7:0];
				REG_FLOW_SKIP_EN:  cfg_q.flow_skip_enable  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_GATE_MM:       prdata = DATA_W'(cfg_q.gate_mm);
			REG_RATE_MM_PER_S: prdata = DATA_W'(cfg_q.rate_mm_per_s);
			REG_HOLD_FARTHER:  prdata = DATA_W'(cfg_q.hold_farther);
			REG_HOLD_CLOSER:   prdata = DATA_W'(cfg_q.hold_closer);
			REG_STABLE_MM:     prdata = DATA_W'(cfg_q.stable_mm);
			REG_PIN_SCALE:     prdata = DATA_W'(cfg_q.pin_scale_eighths);
			REG_FLOW_SKIP_EN:  prdata = DATA_W'(cfg_q.flow_skip_enable);
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ src/rig_decide.sv @@
// Single-pass gate decision: result and next tracker state for one reading.
`default_nettype none
module rig_decide import rig_pkg::*; (
	input  meas_t       meas,
	input  cfg_t        cfg,
	input  gate_state_t st,
	output res_t        res,
	output gate_state_t st_next
);

	logic               gate_go;
	logic [DIST_W-1:0]  d;
	logic [DIST_W-1:0]  ref_d, prev_d;
	logic [TIME_W-1:0]  ref_t, dt;
	logic [19:0]        gate_um;
	logic [45:0]        rate_um;
	logic [46:0]        allowed_um;
	logic [DIST_W-1:0]  ref_diff, prev_diff;
	logic [25:0]        diff_um;
	logic               far, stable, reject;
	logic [COUNT_W-1:0] hold;
	logic [23:0]        pinned;
	logic [UNOISE_W-1:0] pin_noise;

	assign d       = meas.distance_mm;
	assign gate_go = meas.tilt_ok & meas.flying & (d >= MIN_RANGE_MM);

	// First reading seeds the reference and the previous sample
	assign ref_d  = st.ref_valid ? st.ref_distance  : d;
	assign ref_t  = st.ref_valid ? st.ref_time      : meas.time_ms;
	assign prev_d = st.ref_valid ? st.prev_distance : d;

	// Allowance in micrometres: gate*1000 + rate * elapsed ms
	assign dt         = meas.time_ms - ref_t;
	assign gate_um    = 20'(cfg.gate_mm) * 20'(UM_PER_MM);
	assign rate_um    = 46'(cfg.rate_mm_per_s) * 46'(dt);
	assign allowed_um = 47'(gate_um) + 47'(rate_um);

	assign ref_diff  = (d > ref_d) ? d - ref_d : ref_d - d;
	assign prev_diff = (d > prev_d) ? d - prev_d : prev_d - d;
	assign diff_um   = 26'(ref_diff) * 26'(UM_PER_MM);

	assign far    = 47'(diff_um) > allowed_um;
	assign stable = prev_diff < DIST_W'(cfg.stable_mm);
	assign hold   = (d < ref_d) ? cfg.hold_closer : cfg.hold_farther;
	assign reject = (cfg.gate_mm != '0) & (far | ~stable) & (st.reject_count < hold);

	// Pinned noise, saturated
	assign pinned    = 24'(meas.noise_mm) * 24'(cfg.pin_scale_eighths);
	assign pin_noise = (pinned > 24'(NOISE_MAX)) ? NOISE_MAX : pinned[UNOISE_W-1:0];

	// Next state
	always_comb begin
		st_next = st;
		if (gate_go) begin
			st_next.ref_valid     = 1'b1;
			st_next.prev_distance = d;
			if (reject) begin
				st_next.ref_distance = ref_d;
				st_next.ref_time     = ref_t;
				st_next.reject_count = st.reject_count + COUNT_W'(1);
				st_next.gated_flag   = 1'b1;
			end else begin
				st_next.ref_distance = d;
				st_next.ref_time     = meas.time_ms;
				st_next.reject_count = '0;
				st_next.gated_flag   = 1'b0;
			end
		end
	end

	// Result
	always_comb begin
		res.action       = ACT_NONE;
		res.update_noise = '0;
		if (!meas.tilt_ok) begin
			res.action = ACT_NONE;
		end else if (!meas.flying) begin
			res.action = ACT_GROUND;
		end else if (gate_go) begin
			if (reject) begin
				if (cfg.pin_scale_eighths != '0) begin
					res.action       = ACT_PIN;
					res.update_noise = pin_noise;
				end else begin
					res.action = ACT_COAST;
				end
			end else begin
				res.action       = ACT_ACCEPT;
				res.update_noise = UNOISE_W'({meas.noise_mm, 3'b000});
			end
		end
		res.reference_mm = st_next.ref_distance;
		res.reject_run   = st_next.reject_count;
		res.flow_skip    = cfg.flow_skip_enable & st_next.gated_flag;
	end

endmodule
`default_nettype wire

@@ src/range_innovation_gate.sv @@
// Range innovation gate: pipeline registers, tracker state and APB configuration.
// A reading in the input register moves to the output register when that is free or drained;
// one reading per cycle unless output stalls; tracker state updates in the same cycle that a
// reading leaves the input register, through one 14x32 multiply, add and compare.
// Reset (arst_n low, asynchronous): pipeline empty, tracker state zero, registers to defaults.
`default_nettype none
module range_innovation_gate import rig_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              meas_valid,
	output logic                   meas_ready,
	input  meas_t                  meas,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_t                   res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t        cfg;
	meas_t       meas_s1;
	logic        valid_s1;
	res_t        res_s2;
	logic        valid_s2;
	gate_state_t st_q, st_next;
	res_t        res_comb;
	logic        adv_s1, take;

	rig_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rig_decide u_decide (
		.meas    (meas_s1),
		.cfg     (cfg),
		.st      (st_q),
		.res     (res_comb),
		.st_next (st_next)
	);

	// Handshake: s1 moves when the result register is free or being drained
	assign adv_s1     = valid_s1 & (~valid_s2 | res_ready);
	assign meas_ready = ~valid_s1 | adv_s1;
	assign take       = meas_valid & meas_ready;
	assign res_valid  = valid_s2;
	assign res        = res_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (meas_ready) valid_s1 <= take;
			if (~valid_s2 | res_ready) valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take) meas_s1 <= meas;
		if (adv_s1) res_s2 <= res_comb;
	end

	// Tracker state advances once per reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

endmodule
`default_nettype wire

@@ dv/rig_checker.sv @@
// Scoreboard for the range innovation gate: follows register writes, predicts each result and compares.
module rig_checker import rig_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              meas_valid,
	input  wire logic              meas_ready,
	input  meas_t                  meas,
	input  wire logic              res_valid,
	input  wire logic              res_ready,
	input  res_t                   res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic [DATA_W-1:0] prdata,
	input  wire logic              pready,
	output int                     mismatches,
	output int                     pending,
	output int                     checked
);

	cfg_t        cfg;
	gate_state_t trk;
	res_t        gate_results_q[$];
	int          n_bad;
	int          n_checked;

	// Tracker model: one reading in, one result out, tracker state updated in place
	function automatic res_t gate_reading(input meas_t m);
		res_t         r;
		logic [63:0]  allowed_um;
		logic [63:0]  diff_um;
		logic [31:0]  elapsed_ms;
		logic [15:0]  offset_mm;
		logic [15:0]  jump_mm;
		logic [15:0]  hold;
		logic [23:0]  pinned;
		logic         far_off;
		logic         steady;
		r.action = ACT_NONE;
		r.update_noise = '0;
		if (!m.tilt_ok) begin
			r.action = ACT_NONE;
		end else if (!m.flying) begin
			r.action = ACT_GROUND;
		end else if (m.distance_mm >= MIN_RANGE_MM) begin
			// first usable reading seeds the reference
			if (!trk.ref_valid) begin
				trk.ref_valid = 1'b1;
				trk.ref_distance = m.distance_mm;
				trk.ref_time = m.time_ms;
				trk.prev_distance = m.distance_mm;
			end
			elapsed_ms = m.time_ms - trk.ref_time;
			allowed_um = cfg.gate_mm * 64'd1000 + cfg.rate_mm_per_s * {32'd0, elapsed_ms};
			offset_mm = (m.distance_mm > trk.ref_distance) ? m.distance_mm - trk.ref_distance
				: trk.ref_distance - m.distance_mm;
			diff_um = offset_mm * 64'd1000;
			far_off = diff_um > allowed_um;
			jump_mm = (m.distance_mm > trk.prev_distance) ? m.distance_mm - trk.prev_distance
				: trk.prev_distance - m.distance_mm;
			steady = jump_mm < 16'(cfg.stable_mm);
			trk.prev_distance = m.distance_mm;
			hold = (m.distance_mm < trk.ref_distance) ? cfg.hold_closer : cfg.hold_farther;
			if (cfg.gate_mm != 0 && (far_off || !steady) && trk.reject_count < hold) begin
				trk.reject_count = trk.reject_count + 16'd1;
				trk.gated_flag = 1'b1;
				if (cfg.pin_scale_eighths != 0) begin
					r.action = ACT_PIN;
					pinned = 24'(m.noise_mm) * 24'(cfg.pin_scale_eighths);
					r.update_noise = (pinned > 24'(NOISE_MAX)) ? NOISE_MAX
						: pinned[UNOISE_W-1:0];
				end else begin
					r.action = ACT_COAST;
				end
			end else begin
				trk.reject_count = '0;
				trk.gated_flag = 1'b0;
				trk.ref_distance = m.distance_mm;
				trk.ref_time = m.time_ms;
				r.action = ACT_ACCEPT;
				r.update_noise = UNOISE_W'({m.noise_mm, 3'b000});
			end
		end
		r.reference_mm = trk.ref_distance;
		r.reject_run = trk.reject_count;
		r.flow_skip = cfg.flow_skip_enable & trk.gated_flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t              want;
		logic [DATA_W-1:0] rd_want;
		if (!arst_n) begin
			cfg.gate_mm = RST_GATE_MM;
			cfg.rate_mm_per_s = RST_RATE_MM_PER_S;
			cfg.hold_farther = RST_HOLD_FARTHER;
			cfg.hold_closer = RST_HOLD_CLOSER;
			cfg.stable_mm = RST_STABLE_MM;
			cfg.pin_scale_eighths = RST_PIN_SCALE;
			cfg.flow_skip_enable = RST_FLOW_SKIP_EN;
			trk = '0;
			gate_results_q.delete();
			n_bad = 0;
			n_checked = 0;
		end else begin
			// register port: writes update our copy, reads are compared against it
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr)
					{REG_GATE_MM, 2'b00}:       cfg.gate_mm = pwdata[9:0];
					{REG_RATE_MM_PER_S, 2'b00}: cfg.rate_mm_per_s = pwdata[13:0];
					{REG_HOLD_FARTHER, 2'b00}:  cfg.hold_farther = pwdata[15:0];
					{REG_HOLD_CLOSER, 2'b00}:   cfg.hold_closer = pwdata[15:0];
					{REG_STABLE_MM, 2'b00}:     cfg.stable_mm = pwdata[9:0];
					{REG_PIN_SCALE, 2'b00}:     cfg.pin_scale_eighths = pwdata[7:0];
					{REG_FLOW_SKIP_EN, 2'b00}:  cfg.flow_skip_enable = pwdata[0];
					default: ;
					endcase
				end else begin
					rd_want = '0;
					case (paddr)
					{REG_GATE_MM, 2'b00}:       rd_want = DATA_W'(cfg.gate_mm);
					{REG_RATE_MM_PER_S, 2'b00}: rd_want = DATA_W'(cfg.rate_mm_per_s);
					{REG_HOLD_FARTHER, 2'b00}:  rd_want = DATA_W'(cfg.hold_farther);
					{REG_HOLD_CLOSER, 2'b00}:   rd_want = DATA_W'(cfg.hold_closer);
					{REG_STABLE_MM, 2'b00}:     rd_want = DATA_W'(cfg.stable_mm);
					{REG_PIN_SCALE, 2'b00}:     rd_want = DATA_W'(cfg.pin_scale_eighths);
					{REG_FLOW_SKIP_EN, 2'b00}:  rd_want = DATA_W'(cfg.flow_skip_enable);
					default: ;
					endcase
					if (prdata !== rd_want) begin
						n_bad++;
						if (n_bad <= 10)
							$display("rig_checker: read of 0x%0h returned 0x%0h, expected 0x%0h",
								paddr, prdata, rd_want);
					end
				end
			end
			// results first: a reading taken at this edge cannot have its result out yet
			if (res_valid && res_ready) begin
				if (gate_results_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("rig_checker: result with no reading outstanding");
				end else begin
					want = gate_results_q.pop_front();
					n_checked++;
					if (res.action !== want.action || res.reference_mm !== want.reference_mm ||
					    res.update_noise !== want.update_noise ||
					    res.reject_run !== want.reject_run || res.flow_skip !== want.flow_skip) begin
						n_bad++;
						if (n_bad <= 10)
							$display("rig_checker: result %0d act/ref/noise/run/skip %s",
								n_checked, $sformatf("expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
								want.action, want.reference_mm, want.update_noise,
								want.reject_run, want.flow_skip, res.action, res.reference_mm,
								res.update_noise, res.reject_run, res.flow_skip));
					end
				end
			end
			if (meas_valid && meas_ready)
				gate_results_q.push_back(gate_reading(meas));
		end
		mismatches <= n_bad;
		pending <= gate_results_q.size();
		checked <= n_checked;
	end

endmodule

@@ dv/tb.sv @@
// Testbench top for the range innovation gate: clock, reset, readings, register settings and verdict.
module tb;
	import rig_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              meas_valid = 1'b0;
	logic              meas_ready;
	meas_t             meas = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_t              res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                mismatches;
	int                pending;
	int                checked;

	// sender and receiver pacing
	int          burst_left = 0;
	int          stall_mode = 0;
	int          mode_left = 0;
	int          stall_left = 0;
	int          cycle_count = 0;
	int          readings_sent = 0;
	int          settings_used = 1;

	// flight profile for random readings
	int          alt = 500;
	int          step_mm = 25;
	logic [31:0] tnow = 32'd0;

	range_innovation_gate dut (
		.clk(clk), .arst_n(arst_n),
		.meas_valid(meas_valid), .meas_ready(meas_ready), .meas(meas),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rig_checker chk (
		.clk(clk), .arst_n(arst_n),
		.meas_valid(meas_valid), .meas_ready(meas_ready), .meas(meas),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mismatches(mismatches), .pending(pending), .checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// result-side backpressure: always ready, coin flips, or stall bursts
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
		0: res_ready <= 1'b1;
		1: res_ready <= 1'($urandom_range(0, 1));
		default: begin
			if (stall_left != 0) begin
				res_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				res_ready <= 1'b1;
				stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			end
		end
		endcase
	end

	function automatic meas_t reading(input logic [15:0] d, input logic [31:0] t,
		input logic [15:0] n, input logic fly, input logic tilt);
		meas_t m;
		m.distance_mm = d;
		m.time_ms = t;
		m.noise_mm = n;
		m.flying = fly;
		m.tilt_ok = tilt;
		return m;
	endfunction

	// mostly a plausible flight; some raw noise, bad tilt, ground and short readings
	function automatic meas_t next_reading();
		meas_t m;
		int    pick;
		int    delta;
		pick = $urandom_range(0, 99);
		m.distance_mm = 16'($urandom);
		m.time_ms = $urandom;
		m.noise_mm = 16'($urandom);
		m.flying = 1'b1;
		m.tilt_ok = 1'b1;
		if (pick < 5) begin
			m.flying = 1'($urandom_range(0, 1));
			m.tilt_ok = 1'($urandom_range(0, 1));
			return m;
		end
		tnow = tnow + (($urandom_range(0, 99) == 0) ? $urandom : $urandom_range(0, 120));
		if ($urandom_range(0, 99) < 85) begin
			delta = $urandom_range(0, 2 * step_mm);
			alt = alt + delta - step_mm;
		end else begin
			delta = $urandom_range(60, 4000);
			alt = $urandom_range(0, 1) ? alt + delta : alt - delta;
		end
		if (alt < 20)
			alt = 20 + $urandom_range(0, 50);
		if (alt > 65535)
			alt = 65535;
		m.distance_mm = 16'(alt);
		m.time_ms = tnow;
		m.noise_mm = 16'($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom);
		if (pick < 10)
			m.tilt_ok = 1'b0;
		else if (pick < 15)
			m.flying = 1'b0;
		else if (pick < 19)
			m.distance_mm = 16'($urandom_range(0, 19));
		return m;
	endfunction

	// one item: start a new burst (maybe after a gap) when the old one is used up
	task automatic send_reading(input meas_t m);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				meas_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		meas_valid <= 1'b1;
		meas <= m;
		do @(posedge clk); while (!meas_ready);
		burst_left--;
		readings_sent++;
	endtask

	task automatic run_flight(input int n);
		for (int i = 0; i < n; i++)
			send_reading(next_reading());
	endtask

	// hold off until every reading has its result back
	task automatic wait_all_results();
		meas_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// APB transfer: setup then access; back-to-back transfers keep psel high
	task automatic reg_access(input logic wr, input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// random bits above the register width; the block must drop them
	function automatic logic [31:0] with_junk(input int value, input int w);
		logic [31:0] junk;
		junk = $urandom_range(0, 1) ? ($urandom << w) : 32'd0;
		return junk | value;
	endfunction

	task automatic apply_settings(input int g, input int r, input int hf, input int hc,
		input int s, input int p, input int f);
		wait_all_results();
		reg_access(1'b1, REG_GATE_MM, with_junk(g, 10));
		reg_access(1'b1, REG_RATE_MM_PER_S, with_junk(r, 14));
		reg_access(1'b1, REG_HOLD_FARTHER, with_junk(hf, 16));
		reg_access(1'b1, REG_HOLD_CLOSER, with_junk(hc, 16));
		reg_access(1'b1, REG_STABLE_MM, with_junk(s, 10));
		reg_access(1'b1, REG_PIN_SCALE, with_junk(p, 8));
		reg_access(1'b1, REG_FLOW_SKIP_EN, with_junk(f, 1));
		for (int i = REG_GATE_MM; i <= REG_FLOW_SKIP_EN; i++)
			reg_access(1'b0, 3'(i), 32'd0);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
		step_mm = (s > 3) ? s / 2 : 2;
		alt = $urandom_range(20, 3000);
		tnow = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4000);
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at reset settings
		send_reading(reading(16'd1000, 32'd10, 16'd7, 1'b1, 1'b0));          // bad tilt
		send_reading(reading(16'd500, 32'd11, 16'd9, 1'b0, 1'b1));           // on ground
		send_reading(reading(16'd19, 32'd12, 16'd3, 1'b1, 1'b1));            // just short
		send_reading(reading(16'd0, 32'd13, 16'd3, 1'b1, 1'b1));             // zero range
		send_reading(reading(16'd20, 32'd1000, 16'd0, 1'b1, 1'b1));          // seeds reference
		send_reading(reading(16'hFFFF, 32'd1001, 16'hFFFF, 1'b1, 1'b1));     // huge jump, pinned
		send_reading(reading(16'd60, 32'd1002, 16'd5, 1'b1, 1'b1));          // near ref, unstable
		send_reading(reading(16'd61, 32'd1003, 16'hFFFF, 1'b1, 1'b1));       // accepted
		send_reading(reading(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0));
		send_reading(reading(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1));
		send_reading(reading(16'd70, 32'hFFFF_FFF0, 16'd11, 1'b1, 1'b1));    // long time since ref
		send_reading(reading(16'd75, 32'h0000_0010, 16'd12, 1'b1, 1'b1));    // timestamp wraps
		send_reading(reading(16'd75, 32'h0000_0011, 16'd1, 1'b1, 1'b1));     // equal to ref
		send_reading(reading(16'd125, 32'h0000_0012, 16'd2, 1'b1, 1'b1));    // step equals limit
		send_reading(reading(16'd124, 32'h0000_0013, 16'd2, 1'b1, 1'b1));
		send_reading(reading(16'd250, 32'h0000_0014, 16'd3, 1'b1, 1'b1));
		send_reading(reading(16'd251, 32'h0000_0015, 16'd3, 1'b1, 1'b1));    // far but steady
		send_reading(reading(16'd251, 32'h0000_006D, 16'd3, 1'b1, 1'b1));    // exactly at allowance
		send_reading(reading(16'd200, 32'h0000_006E, 16'd4, 1'b1, 1'b1));    // closer, unstable
		send_reading(reading(16'd60000, 32'h0000_006F, 16'd4, 1'b1, 1'b1));
		send_reading(reading(16'd30, 32'h0000_0070, 16'd4, 1'b1, 1'b1));

		tnow = 32'h0000_0100;
		alt = 300;
		run_flight(60);

		// top of every range, widest registers beyond their nominal range
		apply_settings(1023, 16383, 65535, 65535, 1023, 255, 1);
		run_flight(56);
		// everything off: no gating, zero holds, zero pin scale
		apply_settings(0, 0, 0, 0, 0, 0, 0);
		run_flight(56);
		// short holds with coasting
		apply_settings(50, 10, 3, 5, 20, 0, 1);
		run_flight(56);
		apply_settings(1000, 10000, 1, 2, 1000, 255, 1);
		run_flight(56);
		apply_settings($urandom_range(0, 1000), $urandom_range(0, 10000), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 1000), $urandom_range(0, 255),
			$urandom_range(0, 1));
		run_flight(56);
		apply_settings($urandom_range(1, 200), $urandom_range(0, 500), $urandom_range(0, 8),
			$urandom_range(0, 8), $urandom_range(0, 100), $urandom_range(0, 255),
			$urandom_range(0, 1));
		run_flight(56);

		wait_all_results();
		$display("tb: %0d readings sent, %0d results checked over %0d register settings",
			readings_sent, checked, settings_used);
		$display("tb: covered tilt, ground, short range, gating limits, holds and wrapped time");
		if (mismatches == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/rig_pkg.sv
src/rig_cfg.sv
src/rig_decide.sv
src/range_innovation_gate.sv
dv/rig_checker.sv
dv/tb.sv
